>>> rtl/core/gcm_pkg.sv
package gcm_pkg;

  // fixed field widths
  localparam int DEPTH_W  = 4;
  localparam int SIDE_W   = 6;
  localparam int S_DATA_W = 8;
  localparam int M_DATA_W = 8;
  localparam int M_USER_W = 2;

  // default grid capacity
  localparam int MAX_SIDE_DEF = 32;

  // stored entry: older row in the upper nibble, newer row in the lower
  localparam int ENTRY_W = 2 * DEPTH_W;

  // m_tuser bit positions
  localparam int USER_CAV = 0;
  localparam int USER_END = 1;

  typedef logic [DEPTH_W-1:0] depth_t;

  // the cell under test and its four neighbours
  typedef struct packed {
    depth_t mid;
    depth_t up;
    depth_t below;
    depth_t left;
    depth_t right;
  } nbr_t;

endpackage

>>> rtl/core/gcm_ram.sv
module gcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/gcm_cav.sv
module gcm_cav import gcm_pkg::*; (
  input  nbr_t nbr,
  input  logic inner,
  output logic cav
);

  // strict maximum against all four neighbours, interior cells only
  assign cav = inner
             && (nbr.mid > nbr.up)
             && (nbr.mid > nbr.below)
             && (nbr.mid > nbr.left)
             && (nbr.mid > nbr.right);

endmodule

>>> rtl/core/grid_cavity_marker_core.sv
// cavity map of a square grid of depth digits, 4-neighbour strict maximum
//
// s_tdata carries one depth digit per transaction, cells in raster order.
// m_tdata carries the depth of an emitted cell, m_tuser its cavity flag and
// end-of-row mark, m_tlast marks the last result caused by one input.
// results run one row behind the input: the cell at row r, column c emits
// the cell at row r-1, column c; the input that completes the grid also
// flushes the whole last row. cfg_we/cfg_data set the grid side (0 acts
// as 1, above MAX_SIDE acts as MAX_SIDE) and restart the grid at row 0.
// sequence: an input passes the idle, read and eval states, one for each of
// three accesses to the single row store (read own column, read right
// column, write back). eval registers the result, waiting on a full output
// register; a grid-completing input then reads and emits each flushed cell.
// reset empties the output register, sets the side to 1 and the position
// to row 0, column 0; stored rows are left as they are, no clearing pass.
// when the receiver stalls, the result waits in the output register and
// the block holds the item in flight; s_tready stays low until it is done.
module grid_cavity_marker_core import gcm_pkg::*; #(
  parameter int MAX_SIDE = MAX_SIDE_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // depth [3:0]
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [S_DATA_W-1:0] s_tdata,
  // cell_depth [3:0]
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [M_DATA_W-1:0] m_tdata,
  // is_cavity [0], row_end [1]
  output logic [M_USER_W-1:0] m_tuser,
  output logic                m_tlast,
  // grid_side [5:0]
  input  logic                cfg_we,
  input  logic [SIDE_W-1:0]   cfg_data
);

  localparam int AW = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int NW = $clog2(MAX_SIDE + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_EVAL   = 3'd2;
  localparam logic [2:0] ST_FL_RD  = 3'd3;
  localparam logic [2:0] ST_FL_OUT = 3'd4;

  logic [2:0]    state;
  logic [NW-1:0] side;
  logic [NW-1:0] row_count;
  logic [NW-1:0] col_count;
  logic [NW-1:0] flush_col;
  depth_t        d_hold;
  depth_t        up_q;
  depth_t        mid_q;
  depth_t        left_hold;

  // output register
  logic          out_valid;
  depth_t        out_depth;
  logic          out_cav;
  logic          out_end;
  logic          out_last;

  // row store port
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [ENTRY_W-1:0]  ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic          accept;
  logic          out_free;
  logic          pos_wrap;
  logic [NW-1:0] row_eff;
  logic [NW-1:0] col_eff;
  logic [NW:0]   col_inc;
  logic [NW:0]   row_inc;
  logic [NW:0]   flush_inc;
  logic          has_right;
  logic          row_done;
  logic          grid_done;
  logic          emit;
  logic          eval_go;
  logic          inner;
  logic          cav;
  logic          flush_end;
  nbr_t          nbr;

  assign accept   = s_tvalid && s_tready;
  assign s_tready = (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;

  // position of the incoming cell; out of range restarts the grid
  assign pos_wrap = (row_count >= side) || (col_count >= side);
  assign row_eff  = pos_wrap ? '0 : row_count;
  assign col_eff  = pos_wrap ? '0 : col_count;

  assign col_inc   = {1'b0, col_count} + 1'b1;
  assign row_inc   = {1'b0, row_count} + 1'b1;
  assign flush_inc = {1'b0, flush_col} + 1'b1;
  assign has_right = col_inc < {1'b0, side};
  assign row_done  = !has_right;
  assign grid_done = row_done && (row_inc >= {1'b0, side});
  assign flush_end = (flush_inc == {1'b0, side});

  // first row of a grid produces nothing
  assign emit    = (row_count != '0);
  assign eval_go = (state == ST_EVAL) && (!emit || out_free);

  // interior: not the first two rows of input, not first or last column
  assign inner = (row_count >= NW'(2)) && (col_count != '0) && has_right;

  assign nbr.mid   = mid_q;
  assign nbr.up    = up_q;
  assign nbr.below = d_hold;
  assign nbr.left  = left_hold;
  assign nbr.right = has_right ? ram_rdata[DEPTH_W-1:0] : '0;

  gcm_cav u_cav (
    .nbr   (nbr),
    .inner (inner),
    .cav   (cav)
  );

  // read address: own column on accept, right column in read and eval so the
  // right neighbour stays on the read port, flush column while flushing
  always_comb begin
    case (state)
      ST_IDLE:   ram_raddr = col_eff[AW-1:0];
      ST_READ:   ram_raddr = col_inc[AW-1:0];
      ST_EVAL:   ram_raddr = col_inc[AW-1:0];
      ST_FL_RD:  ram_raddr = flush_col[AW-1:0];
      ST_FL_OUT: ram_raddr = flush_col[AW-1:0];
      default:   ram_raddr = '0;
    endcase
  end

  // write back: current middle moves to the older row, input to the newer
  assign ram_we    = eval_go;
  assign ram_waddr = col_count[AW-1:0];
  assign ram_wdata = {mid_q, d_hold};

  gcm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SIDE)
  ) u_rows (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // sequencer and position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      side      <= NW'(1);
      row_count <= '0;
      col_count <= '0;
      flush_col <= '0;
      left_hold <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_data == '0) begin
          side <= NW'(1);
        end else if (cfg_data > SIDE_W'(MAX_SIDE)) begin
          side <= NW'(MAX_SIDE);
        end else begin
          side <= cfg_data[NW-1:0];
        end
        row_count <= '0;
        col_count <= '0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            row_count <= row_eff;
            col_count <= col_eff;
            state     <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (eval_go) begin
            if (row_done) begin
              col_count <= '0;
              left_hold <= '0;
              if (grid_done) begin
                row_count <= '0;
                flush_col <= '0;
                state     <= ST_FL_RD;
              end else begin
                row_count <= row_inc[NW-1:0];
                state     <= ST_IDLE;
              end
            end else begin
              col_count <= col_inc[NW-1:0];
              left_hold <= mid_q;
              state     <= ST_IDLE;
            end
          end
        end
        ST_FL_RD: begin
          state <= ST_FL_OUT;
        end
        ST_FL_OUT: begin
          if (out_free) begin
            if (flush_end) begin
              state <= ST_IDLE;
            end else begin
              flush_col <= flush_inc[NW-1:0];
              state     <= ST_FL_RD;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      d_hold <= s_tdata[DEPTH_W-1:0];
    end
    if (state == ST_READ) begin
      up_q  <= ram_rdata[ENTRY_W-1:DEPTH_W];
      mid_q <= ram_rdata[DEPTH_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((eval_go && emit) || (state == ST_FL_OUT && out_free)) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eval_go && emit) begin
      out_depth <= mid_q;
      out_cav   <= cav;
      out_end   <= row_done;
      out_last  <= !grid_done;
    end else if (state == ST_FL_OUT && out_free) begin
      out_depth <= ram_rdata[DEPTH_W-1:0];
      out_cav   <= 1'b0;
      out_end   <= flush_end;
      out_last  <= flush_end;
    end
  end

  assign m_tvalid           = out_valid;
  assign m_tdata            = {{(M_DATA_W - DEPTH_W){1'b0}}, out_depth};
  assign m_tuser[USER_CAV]  = out_cav;
  assign m_tuser[USER_END]  = out_end;
  assign m_tlast            = out_last;

endmodule

>>> rtl/core/gcm_chk.sv
module gcm_chk import gcm_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                s_tvalid,
  input logic                s_tready,
  input logic                m_tvalid,
  input logic                m_tready,
  input logic [M_DATA_W-1:0] m_tdata,
  input logic [M_USER_W-1:0] m_tuser,
  input logic                m_tlast
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // one item in flight: no new transaction in the cycle after one
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken in back-to-back cycles");

  // a stalled result holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
      && $stable(m_tuser) && $stable(m_tlast)))
    else $error("stalled result changed");

  // a cavity is never in the last column
  a_cav_inner: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[USER_CAV]) |-> !m_tuser[USER_END])
    else $error("cavity flagged at end of row");

endmodule

bind grid_cavity_marker_core gcm_chk u_gcm_chk (.*);
